// ----- src/csvf_pkg.sv -----
// Package for the CSV column value filter: shared widths, codes and the
// queue word type. No dependencies.
`timescale 1ns / 1ps

package csvf_pkg;

  localparam int MAX_COLUMNS       = 64;
  localparam int MAX_PATTERN_BYTES = 16;

  localparam int CHAR_W    = 8;
  localparam int FIELD_W   = 7;   // field index 0..64
  localparam int COL_IDX_W = 6;   // bit index into the select mask
  localparam int POS_W     = 5;   // byte position, saturates at 31
  localparam int PLEN_W    = 5;
  localparam int COUNT_W   = 7;
  localparam int REG_W     = 64;
  localparam int CFG_IDX_W = 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CH_SEMICOLON = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_DQUOTE    = 8'h22;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;

  localparam logic [POS_W-1:0]  POS_MAX  = 5'd31;
  localparam logic [PLEN_W-1:0] PLEN_MAX = PLEN_W'(MAX_PATTERN_BYTES);

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_MASK  = 2'd3;

  // Operations handed from the parser to the matcher
  typedef enum logic [1:0] {
    OP_TAKE  = 2'd0,
    OP_FIELD = 2'd1,
    OP_ROW   = 2'd2
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] data;
  } qword_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ----- src/csvf_front.sv -----
// Parser front end: runs the quote machine on each accepted byte and turns it
// into a queue word (take byte, end field, end row) or drops it. Uses csvf_pkg.
`timescale 1ns / 1ps

module csvf_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [csvf_pkg::CHAR_W-1:0]  in_char_in,
  input  logic                         in_flush,
  input  csvf_pkg::qstat_t             q_stat,
  output logic                         push,
  output csvf_pkg::qword_t             push_word
);

  typedef enum logic [1:0] {
    Q_UNQUOTED,
    Q_QUOTED,
    Q_AFTER_QUOTE
  } quote_t;

  quote_t quote_r, quote_nxt;
  logic   emit;
  logic   accept;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && emit;

  // Classify the byte and work out the next quote state
  always_comb begin
    quote_nxt      = quote_r;
    emit           = 1'b0;
    push_word.op   = csvf_pkg::OP_TAKE;
    push_word.data = in_char_in;
    if (in_flush || in_char_in == csvf_pkg::CH_NEWLINE) begin
      emit         = 1'b1;
      push_word.op = csvf_pkg::OP_ROW;
      quote_nxt    = Q_UNQUOTED;
    end else begin
      case (quote_r)
        Q_UNQUOTED: begin
          if (in_char_in == csvf_pkg::CH_SEMICOLON) begin
            emit         = 1'b1;
            push_word.op = csvf_pkg::OP_FIELD;
          end else if (in_char_in == csvf_pkg::CH_DQUOTE) begin
            quote_nxt = Q_QUOTED;
          end else begin
            emit = 1'b1;
          end
        end
        Q_QUOTED: begin
          if (in_char_in == csvf_pkg::CH_DQUOTE) begin
            quote_nxt = Q_AFTER_QUOTE;
          end else begin
            emit = 1'b1;
          end
        end
        Q_AFTER_QUOTE: begin
          if (in_char_in == csvf_pkg::CH_SEMICOLON) begin
            emit         = 1'b1;
            push_word.op = csvf_pkg::OP_FIELD;
            quote_nxt    = Q_UNQUOTED;
          end else if (in_char_in == csvf_pkg::CH_DQUOTE) begin
            // doubled quote: one literal quote, back inside quotes
            emit      = 1'b1;
            quote_nxt = Q_QUOTED;
          end
        end
        default: begin
          quote_nxt = Q_UNQUOTED;
        end
      endcase
    end
  end

  // Hold quote state; advance on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quote_r <= Q_UNQUOTED;
    end else if (accept) begin
      quote_r <= quote_nxt;
    end
  end

endmodule

// ----- src/csvf_queue.sv -----
// Short FIFO between parser and matcher, so each side can stall on its own.
// Uses csvf_pkg.
`timescale 1ns / 1ps

module csvf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  csvf_pkg::qword_t  push_word,
  input  logic              pop,
  output csvf_pkg::qword_t  head_word,
  output csvf_pkg::qstat_t  q_stat
);

  csvf_pkg::qword_t                  slot_r [csvf_pkg::QUEUE_DEPTH];
  logic [csvf_pkg::QPTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [csvf_pkg::QCNT_W-1:0]       count_r;
  logic                              do_push, do_pop;

  assign q_stat.full  = (count_r == csvf_pkg::QCNT_W'(csvf_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_word    = slot_r[rd_ptr_r];

  // Store pushed words
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_word;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == csvf_pkg::QPTR_W'(csvf_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == csvf_pkg::QPTR_W'(csvf_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- src/csvf_back.sv -----
// Matcher back end: holds the configuration registers, compares field bytes
// with the pattern, tallies matching selected fields and drives the result
// register. Uses csvf_pkg.
`timescale 1ns / 1ps

module csvf_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [csvf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [csvf_pkg::REG_W-1:0]       cfg_data,
  input  csvf_pkg::qstat_t                 q_stat,
  input  csvf_pkg::qword_t                 head_word,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [csvf_pkg::COUNT_W-1:0]     out_row_match_count,
  output logic                             out_row_matched
);

  logic [csvf_pkg::REG_W-1:0]   pattern_low_r, pattern_high_r, column_mask_r;
  logic [csvf_pkg::PLEN_W-1:0]  pattern_len_r;

  logic [csvf_pkg::FIELD_W-1:0] field_r;
  logic [csvf_pkg::POS_W-1:0]   pos_r;
  logic                         equal_r;
  logic [csvf_pkg::COUNT_W-1:0] tally_r;

  logic                         out_valid_r;
  logic [csvf_pkg::COUNT_W-1:0] out_count_r;

  logic [2*csvf_pkg::REG_W-1:0] pattern;
  logic [csvf_pkg::PLEN_W-1:0]  eff_len;
  logic [csvf_pkg::CHAR_W-1:0]  pat_byte;
  logic                         byte_ok;
  logic                         selected;
  logic                         field_hit;
  logic [csvf_pkg::COUNT_W-1:0] tally_end;
  logic                         out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign pop       = !q_stat.empty &&
                     (head_word.op != csvf_pkg::OP_ROW || out_free);

  // Pattern byte at the current position
  assign pattern  = {pattern_high_r, pattern_low_r};
  assign eff_len  = (pattern_len_r > csvf_pkg::PLEN_MAX) ? csvf_pkg::PLEN_MAX
                                                          : pattern_len_r;
  assign pat_byte = pattern[{pos_r[3:0], 3'b000} +: csvf_pkg::CHAR_W];
  assign byte_ok  = (pos_r < eff_len) && (pat_byte == head_word.data);

  // Field end: selected, still equal and of the right length
  assign selected  = (field_r < csvf_pkg::FIELD_W'(csvf_pkg::MAX_COLUMNS)) &&
                     column_mask_r[field_r[csvf_pkg::COL_IDX_W-1:0]];
  assign field_hit = selected && equal_r && (pos_r == eff_len);
  assign tally_end = tally_r + csvf_pkg::COUNT_W'(field_hit);

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_low_r  <= '0;
      pattern_high_r <= '0;
      pattern_len_r  <= '0;
      column_mask_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        csvf_pkg::REG_PATTERN_LOW:  pattern_low_r  <= cfg_data;
        csvf_pkg::REG_PATTERN_HIGH: pattern_high_r <= cfg_data;
        csvf_pkg::REG_PATTERN_LEN:  pattern_len_r  <= cfg_data[csvf_pkg::PLEN_W-1:0];
        csvf_pkg::REG_COLUMN_MASK:  column_mask_r  <= cfg_data;
        default:                    pattern_low_r  <= pattern_low_r;
      endcase
    end
  end

  // Advance field state on each popped word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_r <= '0;
      pos_r   <= '0;
      equal_r <= 1'b1;
      tally_r <= '0;
    end else if (pop) begin
      case (head_word.op)
        csvf_pkg::OP_TAKE: begin
          if (!byte_ok) begin
            equal_r <= 1'b0;
          end
          if (pos_r != csvf_pkg::POS_MAX) begin
            pos_r <= pos_r + 1'b1;
          end
        end
        csvf_pkg::OP_FIELD: begin
          tally_r <= tally_end;
          if (field_r < csvf_pkg::FIELD_W'(csvf_pkg::MAX_COLUMNS)) begin
            field_r <= field_r + 1'b1;
          end
          pos_r   <= '0;
          equal_r <= 1'b1;
        end
        csvf_pkg::OP_ROW: begin
          tally_r <= '0;
          field_r <= '0;
          pos_r   <= '0;
          equal_r <= 1'b1;
        end
        default: begin
          equal_r <= equal_r;
        end
      endcase
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && head_word.op == csvf_pkg::OP_ROW) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_word.op == csvf_pkg::OP_ROW) begin
      out_count_r <= tally_end;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_row_match_count = out_count_r;
  assign out_row_matched     = (out_count_r != '0);

endmodule

// ----- src/csv_column_value_filter_core.sv -----
// CSV column value filter, top level: parser front end, word queue and
// matcher back end. Uses csvf_pkg, csvf_front, csvf_queue, csvf_back.
//
// Usage: text bytes enter on in_char_in with in_valid/in_ready, one byte a
// cycle. in_flush ends the pending row as a newline would (byte ignored).
// Fields split on ';' with double-quote handling; a doubled quote inside
// quotes is one literal quote. Each field whose index is set in
// column_select_mask is compared with the pattern (pattern_low/high,
// pattern_length). At each row end one result leaves on out_valid/out_ready:
// the count of matching selected fields and a matched flag.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Throughput: one byte a cycle while in_ready is high, set by the quote
// machine and the byte compare in the matcher. A row end accepted with the
// queue empty ahead of it is written into the queue, then popped by the
// matcher, which registers the result and raises out_valid.
// When the receiver stalls, the result register holds its value; the
// four-word queue fills and in_ready then drops until room frees.
// Reset (synchronous, rst_n low) clears the quote state, field state, queue,
// result flag and all configuration registers to zero.
`timescale 1ns / 1ps

module csv_column_value_filter_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [csvf_pkg::CHAR_W-1:0]      in_char_in,
  input  logic                             in_flush,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [csvf_pkg::COUNT_W-1:0]     out_row_match_count,
  output logic                             out_row_matched,
  input  logic                             cfg_we,
  input  logic [csvf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [csvf_pkg::REG_W-1:0]       cfg_data
);

  csvf_pkg::qstat_t q_stat;
  csvf_pkg::qword_t push_word, head_word;
  logic             push, pop;

  csvf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_char_in (in_char_in),
    .in_flush   (in_flush),
    .q_stat     (q_stat),
    .push       (push),
    .push_word  (push_word)
  );

  csvf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .head_word (head_word),
    .q_stat    (q_stat)
  );

  csvf_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .q_stat              (q_stat),
    .head_word           (head_word),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_row_match_count (out_row_match_count),
    .out_row_matched     (out_row_matched)
  );

endmodule

// ----- src/csvf_checker.sv -----
// Port-level checks for the CSV column value filter, bound to the top level.
// Uses csvf_pkg.
`timescale 1ns / 1ps

module csvf_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [csvf_pkg::COUNT_W-1:0]   out_row_match_count,
  input logic                           out_row_matched
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_row_match_count) && $stable(out_row_matched))
    else $error("result changed while stalled");

  // Matched flag agrees with the count
  a_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_row_matched == (out_row_match_count != '0))
    else $error("matched flag disagrees with count");

  // Count never exceeds the column limit
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_row_match_count <= csvf_pkg::COUNT_W'(csvf_pkg::MAX_COLUMNS))
    else $error("match count out of range");

  // Reset leaves no result pending and the input open
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("state not cleared by reset");

endmodule

bind csv_column_value_filter_core csvf_checker u_csvf_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_row_match_count (out_row_match_count),
  .out_row_matched     (out_row_matched)
);

// ----- tb/sv/tb_csv_column_value_filter_core.sv -----
// Testbench for csv_column_value_filter_core: drives CSV text with random gaps and stalls,
// predicts each row result in step with accepted words and checks them in order.
// Depends on csvf_pkg and the csv_column_value_filter_core RTL.
`timescale 1ns / 1ps

module tb_csv_column_value_filter_core;

  typedef enum logic [1:0] {
    QM_PLAIN  = 2'd0,
    QM_QUOTED = 2'd1,
    QM_CLOSED = 2'd2
  } quote_mode_t;

  typedef struct packed {
    logic [csvf_pkg::COUNT_W-1:0] count;
    logic                         matched;
  } row_result_t;

  typedef logic [csvf_pkg::CHAR_W-1:0] text_t[$];

  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_WORDS = 830;
  localparam int MAX_REPORTS  = 10;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic [csvf_pkg::CHAR_W-1:0]    in_char_in;
  logic                           in_flush;
  logic                           out_valid;
  logic                           out_ready;
  logic [csvf_pkg::COUNT_W-1:0]   out_row_match_count;
  logic                           out_row_matched;
  logic                           cfg_we;
  logic [csvf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [csvf_pkg::REG_W-1:0]     cfg_data;

  csv_column_value_filter_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_char_in          (in_char_in),
    .in_flush            (in_flush),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_row_match_count (out_row_match_count),
    .out_row_matched     (out_row_matched),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow configuration and row state of the filter
  logic [csvf_pkg::REG_W-1:0]   shadow_pat_lo;
  logic [csvf_pkg::REG_W-1:0]   shadow_pat_hi;
  logic [csvf_pkg::PLEN_W-1:0]  shadow_pat_len;
  logic [csvf_pkg::REG_W-1:0]   shadow_mask;
  quote_mode_t                  q_mode;
  logic [csvf_pkg::FIELD_W-1:0] fld_idx;
  logic [csvf_pkg::POS_W-1:0]   byte_pos;
  logic                         still_eq;
  logic [csvf_pkg::COUNT_W-1:0] tally;

  row_result_t expected_rows[$];
  text_t       row_text;

  int  item_count;
  int  mismatches;
  bit  gaps_on;

  function automatic logic [csvf_pkg::PLEN_W-1:0] used_length();
    return (shadow_pat_len > csvf_pkg::PLEN_MAX) ? csvf_pkg::PLEN_MAX : shadow_pat_len;
  endfunction

  function automatic logic [csvf_pkg::CHAR_W-1:0] pattern_byte_at(input logic [3:0] idx);
    logic [2*csvf_pkg::REG_W-1:0] whole;
    whole = {shadow_pat_hi, shadow_pat_lo};
    return whole[idx*8 +: 8];
  endfunction

  function automatic void reset_shadow();
    shadow_pat_lo  = '0;
    shadow_pat_hi  = '0;
    shadow_pat_len = '0;
    shadow_mask    = '0;
    q_mode         = QM_PLAIN;
    fld_idx        = '0;
    byte_pos       = '0;
    still_eq       = 1'b1;
    tally          = '0;
  endfunction

  function automatic void compare_byte(input logic [csvf_pkg::CHAR_W-1:0] b);
    if (byte_pos >= used_length() || pattern_byte_at(byte_pos[3:0]) != b) still_eq = 1'b0;
    if (byte_pos < csvf_pkg::POS_MAX) byte_pos = byte_pos + 1'b1;
  endfunction

  function automatic void close_field();
    if (fld_idx < csvf_pkg::MAX_COLUMNS && shadow_mask[fld_idx[csvf_pkg::COL_IDX_W-1:0]] &&
        still_eq && byte_pos == used_length())
      tally = tally + 1'b1;
    if (fld_idx < csvf_pkg::MAX_COLUMNS) fld_idx = fld_idx + 1'b1;
    byte_pos = '0;
    still_eq = 1'b1;
  endfunction

  // Advance the shadow row state by one accepted word
  function automatic void filter_word(input logic [csvf_pkg::CHAR_W-1:0] ch, input logic fl);
    row_result_t res;
    if (fl || ch == csvf_pkg::CH_NEWLINE) begin
      close_field();
      res.count   = tally;
      res.matched = (tally != 0);
      expected_rows.insert(expected_rows.size(), res);
      q_mode   = QM_PLAIN;
      fld_idx  = '0;
      byte_pos = '0;
      still_eq = 1'b1;
      tally    = '0;
    end else begin
      case (q_mode)
        QM_PLAIN: begin
          if (ch == csvf_pkg::CH_SEMICOLON) close_field();
          else if (ch == csvf_pkg::CH_DQUOTE) q_mode = QM_QUOTED;
          else compare_byte(ch);
        end
        QM_QUOTED: begin
          if (ch == csvf_pkg::CH_DQUOTE) q_mode = QM_CLOSED;
          else compare_byte(ch);
        end
        default: begin
          if (ch == csvf_pkg::CH_SEMICOLON) begin
            close_field();
            q_mode = QM_PLAIN;
          end else if (ch == csvf_pkg::CH_DQUOTE) begin
            compare_byte(csvf_pkg::CH_DQUOTE);
            q_mode = QM_QUOTED;
          end
        end
      endcase
    end
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Send one word and hold it until accepted
  task automatic send_word(input logic [csvf_pkg::CHAR_W-1:0] ch, input logic fl);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_char_in <= ch;
    in_flush   <= fl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    filter_word(ch, fl);
    item_count++;
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  // Drop valid, wait for every row result, then let the pipeline empty
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [csvf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [csvf_pkg::REG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      csvf_pkg::REG_PATTERN_LOW:  shadow_pat_lo  = data;
      csvf_pkg::REG_PATTERN_HIGH: shadow_pat_hi  = data;
      csvf_pkg::REG_PATTERN_LEN:  shadow_pat_len = data[csvf_pkg::PLEN_W-1:0];
      default:                    shadow_mask    = data;
    endcase
  endtask

  task automatic configure(input logic [csvf_pkg::REG_W-1:0] lo,
                           input logic [csvf_pkg::REG_W-1:0] hi,
                           input logic [csvf_pkg::REG_W-1:0] len_word,
                           input logic [csvf_pkg::REG_W-1:0] mask);
    write_reg(csvf_pkg::REG_PATTERN_LOW, lo);
    write_reg(csvf_pkg::REG_PATTERN_HIGH, hi);
    write_reg(csvf_pkg::REG_PATTERN_LEN, len_word);
    write_reg(csvf_pkg::REG_COLUMN_MASK, mask);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [csvf_pkg::CHAR_W-1:0] noise_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 8'(8'h61 + $urandom_range(0, 3));
    if (r < 50) return csvf_pkg::CH_SEMICOLON;
    if (r < 60) return csvf_pkg::CH_DQUOTE;
    if (r < 63) return csvf_pkg::CH_NEWLINE;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [csvf_pkg::REG_W-1:0] pattern_word();
    logic [csvf_pkg::REG_W-1:0] w;
    for (int i = 0; i < 8; i++)
      w[i*8 +: 8] = ($urandom_range(0, 3) != 0) ? 8'(8'h61 + $urandom_range(0, 3))
                                                : 8'($urandom_range(0, 255));
    return w;
  endfunction

  // Append one field to the row text, quoted where its content needs it and sometimes at random
  function automatic void build_field();
    logic [csvf_pkg::CHAR_W-1:0] content[$];
    int n, kind, flip, len;
    bit quoted;
    n    = int'(used_length());
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3, 5: begin
        for (int k = 0; k < n; k++) content.insert(content.size(), pattern_byte_at(4'(k)));
        if (kind == 3 && n > 0) begin
          flip = $urandom_range(0, n - 1);
          content[flip] = content[flip] ^ (8'h01 << $urandom_range(0, 7));
        end
        if (kind == 5) content.insert(content.size(), noise_byte());
      end
      4: for (int k = 0; k < n - 1; k++) content.insert(content.size(), pattern_byte_at(4'(k)));
      6: ;
      default: begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 5);
        repeat (len) content.insert(content.size(), noise_byte());
      end
    endcase
    quoted = ($urandom_range(0, 3) == 0);
    foreach (content[i])
      if (content[i] == csvf_pkg::CH_SEMICOLON || content[i] == csvf_pkg::CH_DQUOTE) quoted = 1;
    if (quoted) begin
      row_text.insert(row_text.size(), csvf_pkg::CH_DQUOTE);
      foreach (content[i]) begin
        if (content[i] == csvf_pkg::CH_DQUOTE)
          row_text.insert(row_text.size(), csvf_pkg::CH_DQUOTE);
        row_text.insert(row_text.size(), content[i]);
      end
      row_text.insert(row_text.size(), csvf_pkg::CH_DQUOTE);
      // stray bytes after the closing quote are dropped by the parser
      if ($urandom_range(0, 4) == 0)
        row_text.insert(row_text.size(), 8'(8'h61 + $urandom_range(0, 25)));
    end else begin
      foreach (content[i]) row_text.insert(row_text.size(), content[i]);
    end
  endfunction

  // One row: mostly well-formed fields, sometimes plain noise
  task automatic random_row();
    int r, nfields;
    row_text.delete();
    r = $urandom_range(0, 99);
    if (r < 8) begin
      repeat ($urandom_range(0, 30)) row_text.insert(row_text.size(), noise_byte());
    end else begin
      nfields = (r < 13) ? $urandom_range(60, 70) : $urandom_range(1, 6);
      for (int k = 0; k < nfields; k++) begin
        build_field();
        if (k < nfields - 1) row_text.insert(row_text.size(), csvf_pkg::CH_SEMICOLON);
      end
      // unterminated quote closed by the row end
      if ($urandom_range(0, 19) == 0) begin
        row_text.insert(row_text.size(), csvf_pkg::CH_DQUOTE);
        row_text.insert(row_text.size(), 8'h61);
      end
    end
    foreach (row_text[i]) send_word(row_text[i], 1'b0);
    if ($urandom_range(0, 4) == 0) send_word(8'($urandom_range(0, 255)), 1'b1);
    else send_word(csvf_pkg::CH_NEWLINE, 1'b0);
  endtask

  // Defaults after reset: nothing selected, every row counts zero
  task automatic test_reset_state();
    send_string("a;b\n");
    send_word(8'hFF, 1'b1);
    wait_drained();
  endtask

  // Doubled quotes, bytes after a closing quote, newline inside quotes
  task automatic test_quote_rules();
    configure(64'h0000_0000_6322_6261, 64'h0, 64'd4, 64'h8000_0000_0000_0007);
    send_string("\"ab\"\"c\"zz;ab\"c;\"ab\n");
    send_string("x;\"ab\"\"c\n");
    wait_drained();
  endtask

  // Empty pattern matches empty fields; flush on an empty row
  task automatic test_empty_pattern();
    configure(64'h0, 64'h0, 64'd0, {csvf_pkg::REG_W{1'b1}});
    send_word(csvf_pkg::CH_NEWLINE, 1'b0);
    send_word(csvf_pkg::CH_NEWLINE, 1'b1);
    send_string(";x;\n");
    wait_drained();
  endtask

  // Length above the limit, full-width pattern, long field, raw byte extremes
  task automatic test_long_pattern();
    configure(64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938, 64'hFFFF_FFFF_FFFF_FFFF,
              64'h0000_0000_0000_000F);
    send_string("0123456789ABCDEF;0123456789ABCDEFG;");
    send_string("0123456789ABCDEF0123456789ABCDEF0123;0123456789ABCDEF\015\n");
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b1);
    wait_drained();
  endtask

  // More than MAX_COLUMNS fields: index saturates, last selectable column only
  task automatic test_many_fields();
    configure(64'h0, 64'h0, 64'd0, {csvf_pkg::REG_W{1'b1}});
    repeat (70) send_word(csvf_pkg::CH_SEMICOLON, 1'b0);
    send_word(csvf_pkg::CH_NEWLINE, 1'b0);
    wait_drained();
    configure(64'h0, 64'h0, 64'd0, 64'h8000_0000_0000_0000);
    repeat (63) send_word(csvf_pkg::CH_SEMICOLON, 1'b0);
    send_word(8'h5A, 1'b1);
    wait_drained();
  endtask

  // Random rows over a series of settings, extremes included
  task automatic test_random_rows();
    int target, phase, rows;
    logic [csvf_pkg::REG_W-1:0] lo, hi, len_word, mask;
    target = item_count + RANDOM_WORDS;
    phase  = 0;
    while (item_count < target) begin
      lo   = pattern_word();
      hi   = pattern_word();
      mask = {$urandom, $urandom};
      case (phase % 8)
        0: begin len_word = 64'd0; mask = {csvf_pkg::REG_W{1'b1}}; end
        1: begin len_word = 64'd16; mask = {csvf_pkg::REG_W{1'b1}}; end
        2: len_word = {$urandom, $urandom} & ~64'h1F | 64'($urandom_range(17, 31));
        3: begin len_word = 64'd1; mask = 64'h1; end
        4: len_word = 64'($urandom_range(1, 8));
        5: begin len_word = 64'($urandom_range(0, 16)); mask = 64'h0; end
        6: begin
          len_word = 64'($urandom_range(0, 16));
          mask     = 64'h8000_0000_0000_0001;
        end
        default: begin
          lo       = {$urandom, $urandom};
          hi       = {$urandom, $urandom};
          len_word = {$urandom, $urandom};
        end
      endcase
      configure(lo, hi, len_word, mask);
      gaps_on = ($urandom_range(0, 3) != 0);
      rows = 0;
      while (rows < 15 && item_count < target) begin
        random_row();
        rows++;
      end
      wait_drained();
      phase++;
    end
    gaps_on = 1;
  endtask

  // Receiver: random back-pressure, mostly short stalls
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = draw_gap();
      end
    end
  end

  // Check each accepted row result against the oldest prediction
  always @(posedge clk) begin
    row_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected row result: count %0d matched %0b",
                   out_row_match_count, out_row_matched);
      end else begin
        want = expected_rows.pop_front();
        if (out_row_match_count !== want.count || out_row_matched !== want.matched) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("row result mismatch: expected count %0d matched %0b, got %0d %0b",
                     want.count, want.matched, out_row_match_count, out_row_matched);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb_csv_column_value_filter_core: FAIL");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_char_in = '0;
    in_flush   = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = csvf_pkg::REG_PATTERN_LOW;
    cfg_data   = '0;
    item_count = 0;
    mismatches = 0;
    gaps_on    = 1;
    reset_shadow();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_quote_rules();
    test_empty_pattern();
    test_long_pattern();
    test_many_fields();
    test_random_rows();

    wait_drained();
    if (mismatches == 0 && expected_rows.size() == 0) begin
      $display("tb_csv_column_value_filter_core: PASS");
    end else begin
      $display("tb_csv_column_value_filter_core: FAIL");
    end
    $finish;
  end

endmodule
